### design/bitmap_first_fit_frame_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// bitmap_first_fit_frame_allocator_top_macros.svh
// assertion macros shared by the frame allocator checker
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_FIRST_FIT_FRAME_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BFFA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame allocator assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BFFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame allocator assertion failed");

`endif

### design/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// constants and types of the bitmap first-fit frame allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bffa_pkg;

	// bitmap geometry
	localparam int MAP_BYTES         = 128;
	localparam int INDEX_LIMIT_BYTES = 128;
	localparam int BITS_PER_BYTE     = 8;
	localparam int ACT_BYTES         = (MAP_BYTES < INDEX_LIMIT_BYTES) ?
	                                   MAP_BYTES : INDEX_LIMIT_BYTES;
	localparam int BYTE_W            = (ACT_BYTES > 1) ? $clog2(ACT_BYTES) : 1;

	// scan groups of full flags
	localparam int GRP_LOG    = 4;
	localparam int GRP_BYTES  = 1 << GRP_LOG;
	localparam int NUM_GROUPS = (ACT_BYTES + GRP_BYTES - 1) / GRP_BYTES;
	localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int SCAN_W     = GRP_W + GRP_LOG;
	localparam int FULL_LEN   = 1 << SCAN_W;

	// field widths
	localparam int KIND_W  = 2;
	localparam int FRAME_W = 10;
	localparam int COUNT_W = 11;
	localparam int CFG_W   = 8;
	localparam int BIT_W   = 3;

	// request kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_CHECK = 2'd2
	} kind_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_LOOK,
		ST_RESP
	} state_t;

endpackage

### design/bffa_if.sv
// ----------------------------------------------------------------------------
// bffa_if
// request, response and configuration channels of the frame allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bffa_req_if;
	logic                           valid;
	logic                           ready;
	logic [bffa_pkg::KIND_W-1:0]    kind;
	logic [bffa_pkg::FRAME_W-1:0]   frame_index;
	logic [bffa_pkg::COUNT_W-1:0]   required_count;

	modport source (output valid, kind, frame_index, required_count, input ready);
	modport sink (input valid, kind, frame_index, required_count, output ready);
endinterface

interface bffa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [bffa_pkg::FRAME_W-1:0]   granted_frame;
	logic                           ok;
	logic [bffa_pkg::COUNT_W-1:0]   free_frames;

	modport source (output valid, granted_frame, ok, free_frames, input ready);
	modport sink (input valid, granted_frame, ok, free_frames, output ready);
endinterface

interface bffa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bffa_pkg::CFG_W-1:0]     bitmap_bytes;

	modport source (output valid, bitmap_bytes, input ready);
	modport sink (input valid, bitmap_bytes, output ready);
endinterface

### design/bitmap_first_fit_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_frame_allocator_top
// first-fit frame allocator over a used/free bitmap with a running free count
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (allocate, free frame, check enough free); rsp
//   returns exactly one result per request; cfg writes bitmap_bytes, which
//   re-initializes the allocator (all frames free, count = 8 * bytes).
//   Configure only while no request is in flight.
// Steps, request transfer to rsp valid:
//   check / unused kind: result directly; free: one memory read and one
//   update (result directly when out of range); allocate: one group of 16
//   byte-full flags searched per cycle (8 groups at most), then one memory
//   read and one update; the search alone when no frame is free.
// Throughput: one request at a time; req.ready returns once the result is
//   loaded into the output register.
// Reset: all frames free, bitmap_bytes 128; per-byte valid flags make the
//   bitmap memory read as zero without a clearing pass.
// Stall: a result waits in the output register while rsp.ready is low; a
//   following request is taken but finishes only once that slot drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_first_fit_frame_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	bffa_req_if.sink    req,
	bffa_rsp_if.source  rsp,
	bffa_cfg_if.sink    cfg
);

	localparam int BW  = bffa_pkg::BITS_PER_BYTE;
	localparam int AB  = bffa_pkg::ACT_BYTES;

	// state
	bffa_pkg::state_t                state_q, state_d;
	bffa_pkg::kind_t                 kind_q;
	logic [bffa_pkg::GRP_W-1:0]      grp_q;
	logic [bffa_pkg::BYTE_W-1:0]     byte_q;
	logic [bffa_pkg::BIT_W-1:0]      bit_q;
	logic [bffa_pkg::CFG_W-1:0]      active_q;
	logic [bffa_pkg::COUNT_W-1:0]    counter_q;
	logic [AB-1:0]                   vld_q;
	logic [bffa_pkg::FULL_LEN-1:0]   full_q;
	logic [bffa_pkg::FRAME_W-1:0]    res_granted_q;
	logic                            res_ok_q;
	logic [BW-1:0]                   mem_q [AB];
	logic [BW-1:0]                   rdata_q;

	// output register
	logic                            out_valid_q;
	logic [bffa_pkg::FRAME_W-1:0]    out_granted_q;
	logic                            out_ok_q;
	logic [bffa_pkg::COUNT_W-1:0]    out_free_q;

	// combinational helpers
	logic                            req_xfer, cfg_xfer, rsp_load;
	logic [bffa_pkg::CFG_W-1:0]      cfg_act;
	logic                            free_in_range;
	logic [bffa_pkg::GRP_BYTES-1:0]  grp_cand;
	logic                            grp_hit, grp_last;
	logic [bffa_pkg::GRP_LOG-1:0]    hit_idx;
	logic [bffa_pkg::SCAN_W-1:0]     cand_byte;
	logic [bffa_pkg::SCAN_W-1:0]     grp_base;
	logic [BW-1:0]                   byte_val;
	logic [bffa_pkg::BIT_W-1:0]      zero_bit;
	logic [BW-1:0]                   alloc_byte, free_byte;
	logic                            mem_we;
	logic [BW-1:0]                   mem_wd;

	// handshakes
	assign cfg.ready = (state_q == bffa_pkg::ST_IDLE);
	assign req.ready = (state_q == bffa_pkg::ST_IDLE) && !cfg.valid;
	assign cfg_xfer  = cfg.valid && cfg.ready;
	assign req_xfer  = req.valid && req.ready;
	assign rsp_load  = (state_q == bffa_pkg::ST_RESP) && (!out_valid_q || rsp.ready);

	assign rsp.valid         = out_valid_q;
	assign rsp.granted_frame = out_granted_q;
	assign rsp.ok            = out_ok_q;
	assign rsp.free_frames   = out_free_q;

	// saturate the configured byte count
	assign cfg_act = (cfg.bitmap_bytes > bffa_pkg::CFG_W'(AB)) ?
	                 bffa_pkg::CFG_W'(AB) : cfg.bitmap_bytes;

	assign free_in_range = bffa_pkg::COUNT_W'(req.frame_index) <
	                       bffa_pkg::COUNT_W'({active_q, 3'b000});

	// scan unit: one group of full flags per cycle, then bit search in a byte
	always_comb begin
		grp_base = {grp_q, {bffa_pkg::GRP_LOG{1'b0}}};
		for (int i = 0; i < bffa_pkg::GRP_BYTES; i++) begin
			cand_byte   = grp_base | bffa_pkg::SCAN_W'(i);
			grp_cand[i] = !full_q[cand_byte] &&
			              (bffa_pkg::CFG_W'(cand_byte) < active_q);
		end
		cand_byte = grp_base;
		grp_hit   = |grp_cand;
		hit_idx   = '0;
		for (int i = bffa_pkg::GRP_BYTES - 1; i >= 0; i--) begin
			if (grp_cand[i]) begin
				hit_idx = bffa_pkg::GRP_LOG'(i);
			end
		end
		grp_last = (grp_q == bffa_pkg::GRP_W'(bffa_pkg::NUM_GROUPS - 1)) ||
		           ((bffa_pkg::CFG_W'(grp_base) + bffa_pkg::CFG_W'(bffa_pkg::GRP_BYTES))
		            >= active_q);

		byte_val = vld_q[byte_q] ? rdata_q : '0;
		zero_bit = '0;
		for (int i = BW - 1; i >= 0; i--) begin
			if (!byte_val[i]) begin
				zero_bit = bffa_pkg::BIT_W'(i);
			end
		end
		alloc_byte = byte_val | (BW'(1) << zero_bit);
		free_byte  = byte_val & ~(BW'(1) << bit_q);
	end

	// sequencer next state and memory write
	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wd  = alloc_byte;
		case (state_q)
			bffa_pkg::ST_IDLE: begin
				if (req_xfer) begin
					case (bffa_pkg::kind_t'(req.kind))
						bffa_pkg::KIND_ALLOC: state_d = bffa_pkg::ST_SCAN;
						bffa_pkg::KIND_FREE: begin
							state_d = free_in_range ? bffa_pkg::ST_READ : bffa_pkg::ST_RESP;
						end
						default: state_d = bffa_pkg::ST_RESP;
					endcase
				end
			end
			bffa_pkg::ST_SCAN: begin
				if (grp_hit) begin
					state_d = bffa_pkg::ST_READ;
				end else if (grp_last) begin
					state_d = bffa_pkg::ST_RESP;
				end
			end
			bffa_pkg::ST_READ: state_d = bffa_pkg::ST_LOOK;
			bffa_pkg::ST_LOOK: begin
				state_d = bffa_pkg::ST_RESP;
				if (kind_q == bffa_pkg::KIND_ALLOC) begin
					mem_we = 1'b1;
				end else begin
					mem_we = byte_val[bit_q];
					mem_wd = free_byte;
				end
			end
			bffa_pkg::ST_RESP: begin
				if (rsp_load) begin
					state_d = bffa_pkg::ST_IDLE;
				end
			end
			default: state_d = bffa_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bffa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[byte_q] <= mem_wd;
		end
		rdata_q <= mem_q[byte_q];
	end

	// allocator control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= bffa_pkg::CFG_W'(AB);
			counter_q <= bffa_pkg::COUNT_W'(AB * BW);
			vld_q     <= '0;
			full_q    <= '0;
		end else if (cfg_xfer) begin
			active_q  <= cfg_act;
			counter_q <= bffa_pkg::COUNT_W'({cfg_act, 3'b000});
			vld_q     <= '0;
			full_q    <= '0;
		end else if (state_q == bffa_pkg::ST_LOOK) begin
			if (kind_q == bffa_pkg::KIND_ALLOC) begin
				vld_q[byte_q]                      <= 1'b1;
				full_q[bffa_pkg::SCAN_W'(byte_q)]  <= &alloc_byte;
				if (counter_q != '0) begin
					counter_q <= counter_q - 1'b1;
				end
			end else if (byte_val[bit_q]) begin
				vld_q[byte_q]                      <= 1'b1;
				full_q[bffa_pkg::SCAN_W'(byte_q)]  <= 1'b0;
				counter_q                          <= counter_q + 1'b1;
			end
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		case (state_q)
			bffa_pkg::ST_IDLE: begin
				if (req_xfer) begin
					kind_q        <= bffa_pkg::kind_t'(req.kind);
					grp_q         <= '0;
					byte_q        <= bffa_pkg::BYTE_W'(req.frame_index >> bffa_pkg::BIT_W);
					bit_q         <= req.frame_index[bffa_pkg::BIT_W-1:0];
					res_granted_q <= '0;
					res_ok_q      <= (bffa_pkg::kind_t'(req.kind) == bffa_pkg::KIND_CHECK) &&
					                 (counter_q >= req.required_count);
				end
			end
			bffa_pkg::ST_SCAN: begin
				if (grp_hit) begin
					byte_q <= bffa_pkg::BYTE_W'(grp_base | bffa_pkg::SCAN_W'(hit_idx));
				end else begin
					grp_q <= grp_q + 1'b1;
				end
			end
			bffa_pkg::ST_LOOK: begin
				if (kind_q == bffa_pkg::KIND_ALLOC) begin
					res_granted_q <= bffa_pkg::FRAME_W'({byte_q, zero_bit});
					res_ok_q      <= 1'b1;
				end else begin
					res_ok_q      <= byte_val[bit_q];
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			out_granted_q <= res_granted_q;
			out_ok_q      <= res_ok_q;
			out_free_q    <= counter_q;
		end
	end

endmodule

### design/bffa_chk.sv
// ----------------------------------------------------------------------------
// bffa_chk
// port-level checks on the frame allocator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_first_fit_frame_allocator_top_macros.svh"

module bffa_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [bffa_pkg::FRAME_W-1:0]   rsp_granted_frame,
	input logic                           rsp_ok,
	input logic [bffa_pkg::COUNT_W-1:0]   rsp_free_frames
);

	localparam logic [bffa_pkg::COUNT_W-1:0] MAX_FREE =
		bffa_pkg::COUNT_W'(bffa_pkg::ACT_BYTES * bffa_pkg::BITS_PER_BYTE);

	// one request in flight: ready drops right after a request transfer
	`BFFA_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)

	// a nonzero granted frame only comes with a successful allocate
	`BFFA_ASSERT_SAME(a_grant_has_ok, clk, arst_n, rsp_valid && (rsp_granted_frame != '0), rsp_ok)

	// free count never exceeds the number of frames in a full-size bitmap
	`BFFA_ASSERT_SAME(a_free_bound, clk, arst_n, rsp_valid, rsp_free_frames <= MAX_FREE)

	// a stalled result holds its valid, ok flag and free count
	`BFFA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_free_frames) && $stable(rsp_ok))

endmodule

bind bitmap_first_fit_frame_allocator_top bffa_chk u_bffa_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_granted_frame (rsp.granted_frame),
	.rsp_ok            (rsp.ok),
	.rsp_free_frames   (rsp.free_frames)
);
